// ===== rtl/core/software_timer_bank_unit_assert.svh =====
// Assertion macros shared by the checker.
`ifndef SOFTWARE_TIMER_BANK_UNIT_ASSERT_SVH
`define SOFTWARE_TIMER_BANK_UNIT_ASSERT_SVH

// Check that cons holds in every cycle where ante holds.
`define STBU_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cond never holds.
`define STBU_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ===== rtl/core/stbu_pkg.sv =====
package stbu_pkg;

	localparam int MAX_TIMERS = 16;
	localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
	localparam int CNT_W = $clog2(MAX_TIMERS + 1);
	localparam int LIMIT_W = 5;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BAD_HANDLE = 2'd2;

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_SET = 2'd1,
		OP_TEST = 2'd2,
		OP_TICK = 2'd3
	} op_t;

	typedef struct packed {
		op_t op;
		logic [3:0] handle;
		logic [31:0] load_value;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] handle_out;
		logic [31:0] remaining;
		logic [31:0] ticks;
	} rsp_t;

	typedef struct packed {
		op_t op;
		logic [3:0] handle;
		logic [31:0] load_value;
	} job_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_WALK = 1'b1
	} back_state_t;

endpackage

// ===== rtl/core/stbu_queue.sv =====
module stbu_queue
	import stbu_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic push,
	input job_t push_job,
	input logic pop,
	output job_t head,
	output logic empty,
	output logic full
);

	job_t entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ===== rtl/core/stbu_front.sv =====
module stbu_front
	import stbu_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input cmd_t cmd,
	input logic cfg_we,
	input logic [LIMIT_W-1:0] cfg_data,
	input logic q_full,
	output logic busy,
	output logic push,
	output job_t push_job,
	output logic [CNT_W-1:0] limit_eff
);

	logic [LIMIT_W-1:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_data;
		end
	end

	// Clamp the limit to the bank size.
	assign limit_eff = (32'(limit_q) > MAX_TIMERS) ? CNT_W'(MAX_TIMERS) : CNT_W'(limit_q);

	assign busy = q_full;
	assign push = start && !q_full;

	always_comb begin
		push_job.op = cmd.op;
		push_job.handle = cmd.handle;
		push_job.load_value = cmd.load_value;
	end

endmodule

// ===== rtl/core/stbu_back.sv =====
module stbu_back
	import stbu_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic q_empty,
	input job_t head,
	input logic [CNT_W-1:0] limit_eff,
	output logic pop,
	output logic done,
	output rsp_t rsp
);

	back_state_t state_q;
	back_state_t state_d;
	logic [CNT_W-1:0] alloc_q;
	logic [31:0] ticks_q;
	logic [IDX_W-1:0] idx_q;
	logic [31:0] counts_q [MAX_TIMERS];
	logic done_q;
	rsp_t rsp_q;

	logic handle_ok;
	logic walk_last;
	logic [IDX_W-1:0] rd_addr;
	logic [31:0] rd_data;
	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [31:0] wr_data;
	logic alloc_inc;
	logic tick_inc;
	logic idx_clr;
	logic idx_inc;
	logic done_d;
	rsp_t rsp_d;

	assign done = done_q;
	assign rsp = rsp_q;

	assign handle_ok = (32'(head.handle) < 32'(alloc_q));
	assign walk_last = ((CNT_W'(idx_q) + CNT_W'(1)) == alloc_q);
	assign rd_addr = (state_q == BK_WALK) ? idx_q : IDX_W'(head.handle);
	assign rd_data = counts_q[rd_addr];

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty && head.op == OP_TICK && alloc_q != '0) begin
					state_d = BK_WALK;
				end
			end
			BK_WALK: begin
				if (walk_last) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		wr_en = 1'b0;
		wr_addr = rd_addr;
		wr_data = '0;
		alloc_inc = 1'b0;
		tick_inc = 1'b0;
		idx_clr = 1'b0;
		idx_inc = 1'b0;
		done_d = 1'b0;
		rsp_d.status = ST_OK;
		rsp_d.handle_out = '0;
		rsp_d.remaining = '0;
		rsp_d.ticks = ticks_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					case (head.op)
						OP_CREATE: begin
							done_d = 1'b1;
							if (alloc_q < limit_eff) begin
								wr_en = 1'b1;
								wr_addr = IDX_W'(alloc_q);
								alloc_inc = 1'b1;
								rsp_d.handle_out = 4'(alloc_q);
							end else begin
								rsp_d.status = ST_FULL;
							end
						end
						OP_SET: begin
							done_d = 1'b1;
							wr_en = handle_ok;
							wr_data = head.load_value;
						end
						OP_TEST: begin
							done_d = 1'b1;
							if (handle_ok) begin
								rsp_d.remaining = rd_data;
							end else begin
								rsp_d.status = ST_BAD_HANDLE;
							end
						end
						OP_TICK: begin
							tick_inc = 1'b1;
							idx_clr = 1'b1;
							rsp_d.ticks = ticks_q + 32'd1;
							done_d = (alloc_q == '0);
						end
						default: done_d = 1'b0;
					endcase
				end
			end
			BK_WALK: begin
				wr_en = (rd_data != '0);
				wr_data = rd_data - 32'd1;
				idx_inc = 1'b1;
				done_d = walk_last;
			end
			default: done_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			alloc_q <= '0;
			ticks_q <= '0;
			idx_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= done_d;
			if (alloc_inc) begin
				alloc_q <= alloc_q + 1'b1;
			end
			if (tick_inc) begin
				ticks_q <= ticks_q + 32'd1;
			end
			if (idx_clr) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			counts_q[wr_addr] <= wr_data;
		end
		if (done_d) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

// ===== rtl/core/software_timer_bank_unit.sv =====
// Bank of down-counting timers. A request is taken on start while busy is low; its
// result shows on rsp for one cycle with done and cannot be held off, so the receiver
// must take every result when it appears. Results come in request order, one per
// request. Each request waits in the request queue until the executor takes it, and
// its result is registered; for a tick the executor first walks the allocated
// timer registers one per cycle. A two-entry request queue lets requests keep
// arriving while the executor works, and busy rises when it is full. Write
// timer_limit through cfg_we/cfg_data only while no request is outstanding.
module software_timer_bank_unit
	import stbu_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input cmd_t cmd,
	output logic busy,
	input logic cfg_we,
	input logic [LIMIT_W-1:0] cfg_data,
	output logic done,
	output rsp_t rsp
);

	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	job_t push_job;
	job_t head;
	logic [CNT_W-1:0] limit_eff;

	stbu_front u_front (
		.clk (clk),
		.arst_n (arst_n),
		.start (start),
		.cmd (cmd),
		.cfg_we (cfg_we),
		.cfg_data (cfg_data),
		.q_full (q_full),
		.busy (busy),
		.push (push),
		.push_job (push_job),
		.limit_eff (limit_eff)
	);

	stbu_queue u_queue (
		.clk (clk),
		.arst_n (arst_n),
		.push (push),
		.push_job (push_job),
		.pop (pop),
		.head (head),
		.empty (q_empty),
		.full (q_full)
	);

	stbu_back u_back (
		.clk (clk),
		.arst_n (arst_n),
		.q_empty (q_empty),
		.head (head),
		.limit_eff (limit_eff),
		.pop (pop),
		.done (done),
		.rsp (rsp)
	);

endmodule

// ===== rtl/core/stbu_checker.sv =====
`include "software_timer_bank_unit_assert.svh"

module stbu_checker
	import stbu_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic done,
	input rsp_t rsp
);

	`STBU_ASSERT_NEVER(a_status_code, done && rsp.status > ST_BAD_HANDLE, "undefined status")
	`STBU_ASSERT_IMPL(a_full_zero, done && rsp.status == ST_FULL, rsp.handle_out == '0 && rsp.remaining == '0, "full result not cleared")
	`STBU_ASSERT_IMPL(a_bad_zero, done && rsp.status == ST_BAD_HANDLE, rsp.handle_out == '0 && rsp.remaining == '0, "bad handle result not cleared")
	`STBU_ASSERT_IMPL(a_grant_ok, done && rsp.handle_out != '0, rsp.status == ST_OK && rsp.remaining == '0, "grant with bad status or count")

endmodule

bind software_timer_bank_unit stbu_checker u_stbu_checker (
	.clk (clk),
	.arst_n (arst_n),
	.done (done),
	.rsp (rsp)
);
